// File: rtl/core/sscd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Scratchpad CRC decode package
// Payload types, byte positions and resolution codes for the scratchpad
// CRC check and temperature decode unit.
// ---------------------------------------------------------------------------
package sscd_pkg;

	localparam int unsigned POS_W = 4;

	localparam logic [POS_W-1:0] POS_TEMP_LSB = 4'd0;
	localparam logic [POS_W-1:0] POS_TEMP_MSB = 4'd1;
	localparam logic [POS_W-1:0] POS_CONFIG   = 4'd4;

	localparam logic [7:0] CRC_POLY       = 8'h8C;
	localparam int unsigned RES_FIELD_LSB = 5;

	typedef enum logic [1:0] {
		RES_9BIT  = 2'd0,
		RES_10BIT = 2'd1,
		RES_11BIT = 2'd2,
		RES_12BIT = 2'd3
	} res_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} scratch_byte_t;

	typedef struct packed {
		logic signed [15:0] temp_centi;
		logic               crc_ok;
		logic               first_reading;
		logic [15:0]        good_reads;
		logic [15:0]        bad_frames;
	} temp_result_t;

endpackage
`default_nettype wire

// File: rtl/core/sensor_scratchpad_crc_decode_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Scratchpad CRC decode unit
// Checks the reflected CRC-8 of a sensor scratchpad frame and decodes the
// temperature bytes into hundredths of a degree, with good and bad counters.
// ---------------------------------------------------------------------------
// A byte is registered in the input register on transfer, and its result,
// if any, is registered in the result register once that register is free.
// Throughput: one byte per cycle unless the check byte waits on a held result,
// set by the single-byte CRC step and the decode path between the two registers.
// Reset clears all frame state, the held temperature and both counters.
module sensor_scratchpad_crc_decode_unit #(
	parameter int unsigned FRAME_BYTES = 9
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   byte_valid,
	output logic                        byte_ready,
	input  wire sscd_pkg::scratch_byte_t byte_data,
	output logic                        result_valid,
	input  wire logic                   result_ready,
	output sscd_pkg::temp_result_t      result_data
);
	import sscd_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

	function automatic logic [7:0] crc_step(input logic [7:0] crc_in, input logic [7:0] b_in);
		logic [7:0] c;
		logic [7:0] b;
		logic       mix;
		c = crc_in;
		b = b_in;
		for (int k = 0; k < 8; k++) begin
			mix = c[0] ^ b[0];
			c = c >> 1;
			if (mix) begin
				c = c ^ CRC_POLY;
			end
			b = b >> 1;
		end
		return c;
	endfunction

	// Rounding half away from zero: add 2 to a positive product and 1 to a
	// negative one, then take the floor of the quarter.
	function automatic logic [15:0] decode_temp(input logic [7:0] lo, input logic [7:0] hi,
		input res_t res);
		logic [15:0] bits;
		logic [20:0] sx;
		logic [20:0] prod;
		logic [20:0] r;
		bits = {hi, lo};
		unique case (res)
			RES_9BIT:  bits = bits & 16'hFFF8;
			RES_10BIT: bits = bits & 16'hFFFC;
			RES_11BIT: bits = bits & 16'hFFFE;
			RES_12BIT: bits = bits;
		endcase
		sx   = {{5{bits[15]}}, bits};
		prod = (sx << 4) + (sx << 3) + sx;
		r    = prod + (prod[20] ? 21'd1 : 21'd2);
		return r[17:2];
	endfunction

	scratch_byte_t     item_s1;
	logic              valid_s1;
	logic [7:0]        crc_q;
	logic [POS_W-1:0]  pos_q;
	logic [7:0]        lo_q;
	logic [7:0]        hi_q;
	res_t              res_q;
	logic              seen_q;
	logic [15:0]       held_q;
	logic [15:0]       good_q;
	logic [15:0]       bad_q;
	logic              out_valid_q;
	temp_result_t      out_q;

	logic [POS_W-1:0]  pos_eff;
	logic [7:0]        crc_eff;
	logic [7:0]        lo_n;
	logic [7:0]        hi_n;
	res_t              res_n;
	logic              is_last;
	logic              crc_match;
	logic [15:0]       temp_n;
	logic              out_free;
	logic              advance;
	logic              emit;

	always_comb begin
		pos_eff = item_s1.frame_start ? '0 : pos_q;
		crc_eff = item_s1.frame_start ? 8'd0 : crc_q;
		lo_n    = lo_q;
		hi_n    = hi_q;
		res_n   = res_q;
		unique case (pos_eff)
			POS_TEMP_LSB: begin
				lo_n  = item_s1.data_byte;
				hi_n  = 8'd0;
				res_n = RES_9BIT;
			end
			POS_TEMP_MSB: begin
				hi_n = item_s1.data_byte;
			end
			POS_CONFIG: begin
				res_n = res_t'(item_s1.data_byte[RES_FIELD_LSB +: 2]);
			end
			default: begin
				lo_n = lo_q;
			end
		endcase
	end

	assign is_last   = (pos_eff >= LAST_POS);
	assign crc_match = (item_s1.data_byte == crc_eff);
	assign temp_n    = decode_temp(lo_n, hi_n, res_n);
	assign out_free  = !out_valid_q || result_ready;
	assign advance   = valid_s1 && (!is_last || out_free);
	assign emit      = advance && is_last;
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= 8'd0;
			pos_q  <= '0;
			lo_q   <= 8'd0;
			hi_q   <= 8'd0;
			res_q  <= RES_9BIT;
			seen_q <= 1'b0;
			held_q <= 16'd0;
			good_q <= 16'd0;
			bad_q  <= 16'd0;
		end else if (advance) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			res_q <= res_n;
			if (is_last) begin
				pos_q <= '0;
				crc_q <= 8'd0;
				if (crc_match) begin
					held_q <= temp_n;
					seen_q <= 1'b1;
					good_q <= good_q + 16'd1;
				end else begin
					bad_q <= bad_q + 16'd1;
				end
			end else begin
				pos_q <= pos_eff + POS_W'(1);
				crc_q <= crc_step(crc_eff, item_s1.data_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.temp_centi    <= crc_match ? temp_n : held_q;
			out_q.crc_ok        <= crc_match;
			out_q.first_reading <= crc_match && !seen_q;
			out_q.good_reads    <= crc_match ? (good_q + 16'd1) : good_q;
			out_q.bad_frames    <= crc_match ? bad_q : (bad_q + 16'd1);
		end
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

	a_counts_track: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_data.good_reads == good_q &&
			result_data.bad_frames == bad_q))
		else $error("result counters differ from the running counters");

	a_held_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_data.temp_centi == held_q))
		else $error("result temperature differs from the held temperature");

	a_first_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_data.first_reading) |-> (result_data.crc_ok && seen_q))
		else $error("first reading flagged without a good frame");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("byte position beyond the check byte");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> (valid_s1 && result_valid && is_last))
		else $error("input stalled without a pending result");

endmodule
`default_nettype wire
